>>> hdl/btmx_pkg.sv
// ============================================================================
// btmx_pkg
// Shared types and constants for the binary trie maximum-XOR engine.
// ============================================================================
package btmx_pkg;

   // Trie sizing
   localparam int MAX_NODES = 32768;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int USED_W    = NODE_W + 1;
   localparam int LINK_W    = NODE_W;
   localparam int ENTRY_W   = 2 * LINK_W;

   // Key and walk-length sizing
   localparam int KEY_WIDTH = 31;
   localparam int KB_W      = 5;
   localparam logic [KB_W-1:0] KEY_BITS_RESET = KB_W'(31);

   // Request actions
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_QUERY  = 2'd1;
   localparam logic [1:0] ACT_CLEAR  = 2'd2;

   // Result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]           action;
      logic [KEY_WIDTH-1:0] key;
   } req_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] best_xor;
      logic [1:0]           status;
   } rsp_type;

endpackage

>>> hdl/binary_trie_max_xor_top.sv
// ============================================================================
// binary_trie_max_xor_top
// Binary trie of keys in a node memory: insert, best-XOR query and clear.
// ============================================================================
//
//  port group   direction   handshake                     content
//  req_*        in          start & !busy                 action, key
//  rsp_*        out         rsp_valid strobe, one cycle   best_xor, status
//  csr_*        in          csr_valid & csr_ready         key_bits (5 bits)
//
//  One node memory entry (two links) is read per cycle, one trie level per cycle.
//  Insert: walk to the first missing branch, then write the new nodes one after
//  another; when the pool cannot hold them the insert is refused with the full
//  status. A query ends early on a dead end. Clear, empty query and unused
//  actions: busy stays low and the strobe follows in the next cycle. Otherwise
//  busy is high from the cycle after the transfer until the strobe cycle; a new
//  item can be started during the strobe. After reset the root entry is cleared
//  in the S_INIT state, with busy high. The receiver cannot stall: each result
//  is presented exactly once.
//
module binary_trie_max_xor_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  btmx_pkg::req_type         req_data,
   output logic                      rsp_valid,
   output btmx_pkg::rsp_type         rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [btmx_pkg::KB_W-1:0] csr_wdata
);
   import btmx_pkg::*;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_INS_WALK,
      S_INS_FILL,
      S_QRY_WALK
   } state_type;

   state_type             state_ff, state_in;
   logic [KB_W-1:0]       key_bits_ff, key_bits_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic [KB_W-1:0]       level_ff, level_in;
   logic [LINK_W-1:0]     cur_ff, cur_in;
   logic [KEY_WIDTH-1:0]  best_ff, best_in;
   logic [USED_W-1:0]     nodes_used_ff, nodes_used_in;
   logic                  keys_stored_ff, keys_stored_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_WIDTH-1:0]  rsp_best_ff, rsp_best_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   // Node memory: {link for bit 1, link for bit 0}
   logic [ENTRY_W-1:0]    link_mem [MAX_NODES];
   logic [ENTRY_W-1:0]    rd_data_ff;
   logic [NODE_W-1:0]     rd_addr;
   logic                  mem_we;
   logic [NODE_W-1:0]     mem_wa;
   logic [ENTRY_W-1:0]    mem_wd;

   // Walk helpers
   logic [LINK_W-1:0]     link0, link1, dir_link, opp_link, alloc, alloc_next, nxt;
   logic [KB_W-1:0]       lvl_m1, lvl_m2, walk_bits;
   logic                  key_bit;
   logic [USED_W-1:0]     free_nodes, need_nodes;
   logic [KEY_WIDTH-1:0]  best_step;

   assign link0      = rd_data_ff[LINK_W-1:0];
   assign link1      = rd_data_ff[ENTRY_W-1:LINK_W];
   assign lvl_m1     = level_ff - KB_W'(1);
   assign lvl_m2     = level_ff - KB_W'(2);
   assign key_bit    = key_ff[lvl_m1];
   assign dir_link   = key_bit ? link1 : link0;
   assign opp_link   = key_bit ? link0 : link1;
   assign alloc      = nodes_used_ff[NODE_W-1:0];
   assign alloc_next = alloc + LINK_W'(1);
   assign free_nodes = USED_W'(MAX_NODES) - nodes_used_ff;
   assign need_nodes = USED_W'(level_ff);
   assign walk_bits  = (key_bits_ff == '0) ? KB_W'(1) : key_bits_ff;

   // Next-state and memory control
   always_comb begin
      state_in       = state_ff;
      key_bits_in    = key_bits_ff;
      key_in         = key_ff;
      level_in       = level_ff;
      cur_in         = cur_ff;
      best_in        = best_ff;
      nodes_used_in  = nodes_used_ff;
      keys_stored_in = keys_stored_ff;
      rsp_valid_in   = 1'b0;
      rsp_best_in    = rsp_best_ff;
      rsp_status_in  = rsp_status_ff;
      rd_addr        = '0;
      mem_we         = 1'b0;
      mem_wa         = cur_ff;
      mem_wd         = '0;
      nxt            = '0;
      best_step      = best_ff;

      // take a register write
      if (csr_valid && csr_ready) begin
         key_bits_in = csr_wdata;
      end

      case (state_ff)
         S_INIT: begin
            // clear the root entry
            mem_we   = 1'b1;
            mem_wa   = '0;
            state_in = S_IDLE;
         end

         S_IDLE: begin
            if (start) begin
               key_in   = req_data.key;
               level_in = walk_bits;
               cur_in   = '0;
               best_in  = '0;
               case (req_data.action)
                  ACT_INSERT: begin
                     state_in = S_INS_WALK;
                  end
                  ACT_QUERY: begin
                     if (keys_stored_ff) begin
                        state_in = S_QRY_WALK;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_best_in   = '0;
                        rsp_status_in = STAT_EMPTY;
                     end
                  end
                  ACT_CLEAR: begin
                     mem_we         = 1'b1;
                     mem_wa         = '0;
                     nodes_used_in  = USED_W'(1);
                     keys_stored_in = 1'b0;
                     rsp_valid_in   = 1'b1;
                     rsp_best_in    = '0;
                     rsp_status_in  = STAT_OK;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_best_in   = '0;
                     rsp_status_in = STAT_OK;
                  end
               endcase
            end
         end

         S_INS_WALK: begin
            if (dir_link == '0) begin
               if (need_nodes > free_nodes) begin
                  // refuse the whole insert
                  rsp_valid_in  = 1'b1;
                  rsp_best_in   = '0;
                  rsp_status_in = STAT_FULL;
                  state_in      = S_IDLE;
               end else begin
                  // hook the first new node under the current one
                  mem_we   = 1'b1;
                  mem_wa   = cur_ff;
                  mem_wd   = key_bit ? {alloc, link0} : {link1, alloc};
                  state_in = S_INS_FILL;
               end
            end else if (level_ff == KB_W'(1)) begin
               // path already present
               keys_stored_in = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_best_in    = '0;
               rsp_status_in  = STAT_OK;
               state_in       = S_IDLE;
            end else begin
               cur_in   = dir_link;
               rd_addr  = dir_link;
               level_in = lvl_m1;
            end
         end

         S_INS_FILL: begin
            // write one new node per cycle, each chained to the next but the last
            mem_we        = 1'b1;
            mem_wa        = alloc;
            nodes_used_in = nodes_used_ff + USED_W'(1);
            if (level_ff == KB_W'(1)) begin
               mem_wd         = '0;
               keys_stored_in = 1'b1;
               rsp_valid_in   = 1'b1;
               rsp_best_in    = '0;
               rsp_status_in  = STAT_OK;
               state_in       = S_IDLE;
            end else begin
               mem_wd   = key_ff[lvl_m2] ? {alloc_next, {LINK_W{1'b0}}}
                                         : {{LINK_W{1'b0}}, alloc_next};
               level_in = lvl_m1;
            end
         end

         S_QRY_WALK: begin
            if (opp_link != '0) begin
               nxt       = opp_link;
               best_step = best_ff | (KEY_WIDTH'(1) << lvl_m1);
            end else begin
               nxt = dir_link;
            end
            best_in = best_step;
            if (nxt == '0 || level_ff == KB_W'(1)) begin
               // dead end or last level: report
               rsp_valid_in  = 1'b1;
               rsp_best_in   = best_step;
               rsp_status_in = STAT_OK;
               state_in      = S_IDLE;
            end else begin
               rd_addr  = nxt;
               level_in = lvl_m1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         key_bits_ff    <= KEY_BITS_RESET;
         nodes_used_ff  <= USED_W'(1);
         keys_stored_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         key_bits_ff    <= key_bits_in;
         nodes_used_ff  <= nodes_used_in;
         keys_stored_ff <= keys_stored_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      key_ff        <= key_in;
      level_ff      <= level_in;
      cur_ff        <= cur_in;
      best_ff       <= best_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Node memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= link_mem[rd_addr];
   end

   assign busy              = (state_ff != S_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data.best_xor = rsp_best_ff;
   assign rsp_data.status   = rsp_status_ff;

endmodule
